### rtl/dfspc_pkg.sv
// Shared constants, input codes and control bundles for the depth-first preorder walk block.
package dfspc_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned VTX_W  = 6;
  localparam int unsigned KIND_W = 2;

  // Default sizing of the graph store.
  localparam int unsigned DEF_MAX_VERTICES = 64;
  localparam int unsigned DEF_MAX_ARCS     = 1024;

  // Input transaction kinds; the remaining code is ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_CLEAR = 2'd2
  } dfspc_kind_e;

  // Access requests towards the adjacency memories.
  typedef struct packed {
    logic ht_rd;   // read head and tail of one vertex
    logic ht_wr;   // write head and tail of one vertex
    logic arc_rd;  // read target and successor of one arc
    logic tgt_wr;  // write the target of a new arc
    logic nxt_wr;  // link the previous tail arc to a new arc
  } dfspc_adj_cmd_t;

  // Requests towards the walk stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } dfspc_stk_cmd_t;

  // Walk stack status.
  typedef struct packed {
    logic empty;
    logic full;
  } dfspc_stk_status_t;

endpackage

### rtl/dfspc_adj_store.sv
// Adjacency memories: per-vertex list head and tail, arc targets and arc successors.
module dfspc_adj_store #(
  parameter int unsigned MaxVertices = dfspc_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MaxArcs     = dfspc_pkg::DEF_MAX_ARCS
) (
  input  logic                                 clk_i,
  input  dfspc_pkg::dfspc_adj_cmd_t            cmd_i,
  input  logic [$clog2(MaxVertices)-1:0]       ht_addr_i,
  input  logic [$clog2(MaxArcs)-1:0]           ht_head_i,
  input  logic [$clog2(MaxArcs)-1:0]           ht_tail_i,
  output logic [$clog2(MaxArcs)-1:0]           ht_head_o,
  output logic [$clog2(MaxArcs)-1:0]           ht_tail_o,
  input  logic [$clog2(MaxArcs)-1:0]           arc_raddr_i,
  output logic [dfspc_pkg::VTX_W-1:0]          arc_target_o,
  output logic [$clog2(MaxArcs)-1:0]           arc_next_o,
  input  logic [$clog2(MaxArcs)-1:0]           tgt_waddr_i,
  input  logic [dfspc_pkg::VTX_W-1:0]          tgt_wdata_i,
  input  logic [$clog2(MaxArcs)-1:0]           nxt_waddr_i,
  input  logic [$clog2(MaxArcs)-1:0]           nxt_wdata_i
);

  localparam int unsigned AIDX_W = $clog2(MaxArcs);
  localparam int unsigned VTX_W  = dfspc_pkg::VTX_W;

  logic [2*AIDX_W-1:0] ht_mem  [MaxVertices];
  logic [VTX_W-1:0]    tgt_mem [MaxArcs];
  logic [AIDX_W-1:0]   nxt_mem [MaxArcs];

  logic [2*AIDX_W-1:0] ht_rd_q;
  logic [VTX_W-1:0]    tgt_rd_q;
  logic [AIDX_W-1:0]   nxt_rd_q;

  // Head and tail memory, one entry per vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ht_wr) begin
      ht_mem[ht_addr_i] <= {ht_head_i, ht_tail_i};
    end
    if (cmd_i.ht_rd) begin
      ht_rd_q <= ht_mem[ht_addr_i];
    end
  end

  // Arc target memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tgt_wr) begin
      tgt_mem[tgt_waddr_i] <= tgt_wdata_i;
    end
    if (cmd_i.arc_rd) begin
      tgt_rd_q <= tgt_mem[arc_raddr_i];
    end
  end

  // Arc successor memory; a tail arc's entry is never followed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.nxt_wr) begin
      nxt_mem[nxt_waddr_i] <= nxt_wdata_i;
    end
    if (cmd_i.arc_rd) begin
      nxt_rd_q <= nxt_mem[arc_raddr_i];
    end
  end

  assign ht_head_o    = ht_rd_q[2*AIDX_W-1:AIDX_W];
  assign ht_tail_o    = ht_rd_q[AIDX_W-1:0];
  assign arc_target_o = tgt_rd_q;
  assign arc_next_o   = nxt_rd_q;

endmodule

### rtl/dfspc_stack.sv
// Walk stack: a vertex memory with its depth counter.
module dfspc_stack #(
  parameter int unsigned MaxArcs = dfspc_pkg::DEF_MAX_ARCS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dfspc_pkg::dfspc_stk_cmd_t      cmd_i,
  input  logic [dfspc_pkg::VTX_W-1:0]    push_data_i,
  output logic [dfspc_pkg::VTX_W-1:0]    pop_data_o,
  output dfspc_pkg::dfspc_stk_status_t   status_o
);

  localparam int unsigned VTX_W  = dfspc_pkg::VTX_W;
  localparam int unsigned DEPTH  = MaxArcs + 1;
  localparam int unsigned SIDX_W = $clog2(DEPTH);
  localparam int unsigned SCNT_W = $clog2(DEPTH + 1);

  logic [VTX_W-1:0]  stk_mem [DEPTH];
  logic [VTX_W-1:0]  rd_q;
  logic [SCNT_W-1:0] depth_q, depth_d;
  logic [SCNT_W-1:0] base;
  logic [SCNT_W-1:0] top_idx;
  logic              wr_en;

  // A clear restarts the stack, so a push in the same cycle lands at the bottom.
  always_comb begin
    base    = cmd_i.clear ? '0 : depth_q;
    top_idx = depth_q - SCNT_W'(1);
    wr_en   = 1'b0;
    depth_d = base;
    if (cmd_i.push && (base != SCNT_W'(DEPTH))) begin
      wr_en   = 1'b1;
      depth_d = base + SCNT_W'(1);
    end else if (cmd_i.pop && (depth_q != '0)) begin
      depth_d = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Stack memory with a registered read of the top entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stk_mem[base[SIDX_W-1:0]] <= push_data_i;
    end
    if (cmd_i.pop) begin
      rd_q <= stk_mem[top_idx[SIDX_W-1:0]];
    end
  end

  assign pop_data_o     = rd_q;
  assign status_o.empty = (depth_q == '0);
  assign status_o.full  = (depth_q == SCNT_W'(DEPTH));

endmodule

### rtl/dfs_preorder_components_unit.sv
// Top level of the depth-first preorder walk with component labels.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       in_valid_i / in_stall_o  kind_i, from_vertex_i, to_vertex_i
//   out      source     out_valid_o / out_stall_i vertex_o, component_o, visit_index_o,
//                                                last_o, arc_overflow_o
//
// An arc load passes through S_LOAD before the next transaction is taken; clear and
// ignored transactions complete in S_IDLE. A walk pops P stack entries, expands X vertices
// that own arcs and pushes A arcs; P is at most A + 1.
// The list chase pushes one arc per cycle.
// Reset clears the list valid bits, visited marks, counters and flags at once.
// A stall on the output holds the walk at its next visit; the last result waits
// until the stack has emptied, so it leaves one visit behind the walk.
module dfs_preorder_components_unit #(
  parameter int unsigned MaxVertices = dfspc_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MaxArcs     = dfspc_pkg::DEF_MAX_ARCS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dfspc_pkg::KIND_W-1:0]  kind_i,
  input  logic [dfspc_pkg::VTX_W-1:0]   from_vertex_i,
  input  logic [dfspc_pkg::VTX_W-1:0]   to_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfspc_pkg::VTX_W-1:0]   vertex_o,
  output logic [dfspc_pkg::VTX_W-1:0]   component_o,
  output logic [dfspc_pkg::VTX_W-1:0]   visit_index_o,
  output logic                          last_o,
  output logic                          arc_overflow_o
);

  localparam int unsigned VTX_W  = dfspc_pkg::VTX_W;
  localparam int unsigned VCMP_W = VTX_W + 1;
  localparam int unsigned VIDX_W = $clog2(MaxVertices);
  localparam int unsigned AIDX_W = $clog2(MaxArcs);
  localparam int unsigned ACNT_W = $clog2(MaxArcs + 1);
  localparam int unsigned OCNT_W = $clog2(MaxVertices + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_ARC   = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [VTX_W-1:0]       src_q, src_d;
  logic [VTX_W-1:0]       dst_q, dst_d;
  logic [ACNT_W-1:0]      arc_total_q, arc_total_d;
  logic [MaxVertices-1:0] has_arcs_q, has_arcs_d;
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [OCNT_W-1:0]      order_q, order_d;
  logic                   ovf_q, ovf_d;
  logic [AIDX_W-1:0]      arc_q, arc_d;
  logic [AIDX_W-1:0]      tail_q, tail_d;

  logic                   pend_valid_q, pend_valid_d;
  logic [VTX_W-1:0]       pend_vertex_q, pend_vertex_d;
  logic [VTX_W-1:0]       pend_index_q, pend_index_d;
  logic                   pend_ovf_q, pend_ovf_d;

  logic                   out_valid_q, out_valid_d;
  logic [VTX_W-1:0]       out_vertex_q, out_vertex_d;
  logic [VTX_W-1:0]       out_comp_q, out_comp_d;
  logic [VTX_W-1:0]       out_index_q, out_index_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ovf_q, out_ovf_d;

  dfspc_pkg::dfspc_adj_cmd_t    adj_cmd;
  dfspc_pkg::dfspc_stk_cmd_t    stk_cmd;
  dfspc_pkg::dfspc_stk_status_t stk_status;

  logic [VIDX_W-1:0]      ht_addr;
  logic [AIDX_W-1:0]      ht_head_wr, ht_tail_wr;
  logic [AIDX_W-1:0]      ht_head_rd, ht_tail_rd;
  logic [AIDX_W-1:0]      arc_raddr;
  logic [VTX_W-1:0]       arc_target;
  logic [AIDX_W-1:0]      arc_next;
  logic [AIDX_W-1:0]      new_arc;
  logic [VTX_W-1:0]       push_data;
  logic [VTX_W-1:0]       pop_data;
  logic [VIDX_W-1:0]      pop_idx;
  logic [VIDX_W-1:0]      src_idx;
  logic                   in_fire;
  logic                   out_free;
  logic                   from_ok, to_ok, pop_ok;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign from_ok  = VCMP_W'(from_vertex_i) < VCMP_W'(MaxVertices);
  assign to_ok    = VCMP_W'(to_vertex_i) < VCMP_W'(MaxVertices);
  assign pop_ok   = VCMP_W'(pop_data) < VCMP_W'(MaxVertices);
  assign pop_idx  = pop_data[VIDX_W-1:0];
  assign src_idx  = src_q[VIDX_W-1:0];
  assign new_arc  = arc_total_q[AIDX_W-1:0];

  // Main sequencer: decodes transactions, appends arcs and drives the walk.
  always_comb begin
    state_d       = state_q;
    src_d         = src_q;
    dst_d         = dst_q;
    arc_total_d   = arc_total_q;
    has_arcs_d    = has_arcs_q;
    visited_d     = visited_q;
    order_d       = order_q;
    ovf_d         = ovf_q;
    arc_d         = arc_q;
    tail_d        = tail_q;
    pend_valid_d  = pend_valid_q;
    pend_vertex_d = pend_vertex_q;
    pend_index_d  = pend_index_q;
    pend_ovf_d    = pend_ovf_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_vertex_d  = out_vertex_q;
    out_comp_d    = out_comp_q;
    out_index_d   = out_index_q;
    out_last_d    = out_last_q;
    out_ovf_d     = out_ovf_q;
    adj_cmd       = '0;
    stk_cmd       = '0;
    ht_addr       = from_vertex_i[VIDX_W-1:0];
    ht_head_wr    = new_arc;
    ht_tail_wr    = new_arc;
    arc_raddr     = arc_next;
    push_data     = arc_target;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (kind_i)
            dfspc_pkg::KIND_LOAD: begin
              if (from_ok && to_ok) begin
                if (arc_total_q == ACNT_W'(MaxArcs)) begin
                  ovf_d = 1'b1;
                end else begin
                  adj_cmd.ht_rd = 1'b1;
                  src_d         = from_vertex_i;
                  dst_d         = to_vertex_i;
                  state_d       = S_LOAD;
                end
              end
            end
            dfspc_pkg::KIND_START: begin
              if (from_ok) begin
                stk_cmd.clear = 1'b1;
                stk_cmd.push  = 1'b1;
                push_data     = from_vertex_i;
                src_d         = from_vertex_i;
                state_d       = S_POP;
              end
            end
            dfspc_pkg::KIND_CLEAR: begin
              visited_d = '0;
              order_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Append the arc: its target, the link from any old tail, and the new tail (and head of a new list).
      S_LOAD: begin
        ht_addr        = src_idx;
        adj_cmd.tgt_wr = 1'b1;
        adj_cmd.ht_wr  = 1'b1;
        if (has_arcs_q[src_idx]) begin
          adj_cmd.nxt_wr = 1'b1;
          ht_head_wr     = ht_head_rd;
        end
        has_arcs_d[src_idx] = 1'b1;
        arc_total_d         = arc_total_q + ACNT_W'(1);
        state_d             = S_IDLE;
      end

      S_POP: begin
        if (stk_status.empty) begin
          state_d = S_FLUSH;
        end else begin
          stk_cmd.pop = 1'b1;
          state_d     = S_CHECK;
        end
      end

      // Visit the popped vertex unless it is out of range or already seen.
      S_CHECK: begin
        ht_addr = pop_idx;
        if (!pop_ok || visited_q[pop_idx]) begin
          state_d = S_POP;
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_vertex_d = pend_vertex_q;
            out_comp_d   = src_q;
            out_index_d  = pend_index_q;
            out_last_d   = 1'b0;
            out_ovf_d    = pend_ovf_q;
          end
          pend_valid_d       = 1'b1;
          pend_vertex_d      = pop_data;
          pend_index_d       = VTX_W'(order_q);
          pend_ovf_d         = ovf_q;
          visited_d[pop_idx] = 1'b1;
          if (order_q != OCNT_W'(MaxVertices)) begin
            order_d = order_q + OCNT_W'(1);
          end
          if (has_arcs_q[pop_idx]) begin
            adj_cmd.ht_rd = 1'b1;
            state_d       = S_HEAD;
          end else begin
            state_d = S_POP;
          end
        end
      end

      S_HEAD: begin
        adj_cmd.arc_rd = 1'b1;
        arc_raddr      = ht_head_rd;
        arc_d          = ht_head_rd;
        tail_d         = ht_tail_rd;
        state_d        = S_ARC;
      end

      // Push one neighbour per cycle while following the list to its tail.
      S_ARC: begin
        stk_cmd.push = 1'b1;
        if (arc_q == tail_q) begin
          state_d = S_POP;
        end else begin
          adj_cmd.arc_rd = 1'b1;
          arc_d          = arc_next;
        end
      end

      // The held visit is the final one of this walk.
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = pend_vertex_q;
          out_comp_d   = src_q;
          out_index_d  = pend_index_q;
          out_last_d   = 1'b1;
          out_ovf_d    = pend_ovf_q;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      arc_total_q  <= '0;
      has_arcs_q   <= '0;
      visited_q    <= '0;
      order_q      <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      arc_total_q  <= arc_total_d;
      has_arcs_q   <= has_arcs_d;
      visited_q    <= visited_d;
      order_q      <= order_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    src_q         <= src_d;
    dst_q         <= dst_d;
    arc_q         <= arc_d;
    tail_q        <= tail_d;
    pend_vertex_q <= pend_vertex_d;
    pend_index_q  <= pend_index_d;
    pend_ovf_q    <= pend_ovf_d;
    out_vertex_q  <= out_vertex_d;
    out_comp_q    <= out_comp_d;
    out_index_q   <= out_index_d;
    out_last_q    <= out_last_d;
    out_ovf_q     <= out_ovf_d;
  end

  dfspc_adj_store #(
    .MaxVertices (MaxVertices),
    .MaxArcs     (MaxArcs)
  ) u_adj_store (
    .clk_i        (clk_i),
    .cmd_i        (adj_cmd),
    .ht_addr_i    (ht_addr),
    .ht_head_i    (ht_head_wr),
    .ht_tail_i    (ht_tail_wr),
    .ht_head_o    (ht_head_rd),
    .ht_tail_o    (ht_tail_rd),
    .arc_raddr_i  (arc_raddr),
    .arc_target_o (arc_target),
    .arc_next_o   (arc_next),
    .tgt_waddr_i  (new_arc),
    .tgt_wdata_i  (dst_q),
    .nxt_waddr_i  (ht_tail_rd),
    .nxt_wdata_i  (new_arc)
  );

  dfspc_stack #(
    .MaxArcs (MaxArcs)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .push_data_i (push_data),
    .pop_data_o  (pop_data),
    .status_o    (stk_status)
  );

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign vertex_o       = out_vertex_q;
  assign component_o    = out_comp_q;
  assign visit_index_o  = out_index_q;
  assign last_o         = out_last_q;
  assign arc_overflow_o = out_ovf_q;

  // The visit counter never passes the number of vertices.
  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    order_q <= OCNT_W'(MaxVertices))
    else $error("visit counter beyond vertex count");

  // The arc store never holds more arcs than it has room for.
  a_arc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_total_q <= ACNT_W'(MaxArcs))
    else $error("arc count beyond capacity");

  // Each vertex is expanded once, so a push always finds room on the stack.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_cmd.push && !stk_cmd.clear) |-> !stk_status.full)
    else $error("push onto a full walk stack");

  // A held visit never outlives its walk.
  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != S_IDLE && state_q != S_LOAD))
    else $error("held visit outside a walk");

  // A walk ends only after its held visit has left as the final result.
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && pend_valid_q && out_free) |=> (out_valid_q && out_last_q))
    else $error("final result missing at walk end");

endmodule
